// ===== src/fsnp_pkg.sv =====
// Shared constants and types for the FAT short name builder.
// No dependencies; used by fsnp_filter, fsnp_name_build and the top level.
`default_nettype none

package fsnp_pkg;

    localparam int unsigned BASE_LEN   = 8;
    localparam int unsigned EXT_LEN    = 3;
    localparam int unsigned BASE_W     = 8 * BASE_LEN;
    localparam int unsigned EXT_W      = 8 * EXT_LEN;
    localparam int unsigned BCNT_W     = 4;
    localparam int unsigned ECNT_W     = 2;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_SLASH  = 8'h2f;
    localparam logic [7:0] CHAR_DOT    = 8'h2e;
    localparam logic [7:0] UPCASE_MASK = 8'h5f;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_Z      = 8'h5a;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;

    localparam logic [BASE_W-1:0] BASE_BLANK = {BASE_LEN{CHAR_SPACE}};
    localparam logic [EXT_W-1:0]  EXT_BLANK  = {EXT_LEN{CHAR_SPACE}};

    // Filter verdict for one path byte
    typedef struct packed {
        logic       keep;
        logic [7:0] char_out;
    } filt_t;

endpackage

`default_nettype wire

// ===== src/fsnp_filter.sv =====
// Character filter: passes allowed punctuation and digits, upcases letters.
// Depends on fsnp_pkg.
`default_nettype none

module fsnp_filter
(
    input  wire logic [7:0]     char_in,
    output fsnp_pkg::filt_t     result
);

    logic [7:0] masked;

    assign masked = char_in & fsnp_pkg::UPCASE_MASK;

    // Punctuation list, then digits, then letters after masking
    always_comb
    begin
        result.keep     = 1'b0;
        result.char_out = char_in;
        case (char_in)
            8'h20, 8'h21, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2d, 8'h40, 8'h5e, 8'h5f, 8'h60, 8'h7b, 8'h7d, 8'h7e:
            begin
                result.keep = 1'b1;
            end
            default:
            begin
                if (char_in >= fsnp_pkg::CHAR_0 && char_in <= fsnp_pkg::CHAR_9)
                begin
                    result.keep = 1'b1;
                end
                else if (masked >= fsnp_pkg::CHAR_A && masked <= fsnp_pkg::CHAR_Z)
                begin
                    result.keep     = 1'b1;
                    result.char_out = masked;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/fsnp_name_build.sv =====
// Name state: base/extension buffers, counts, dot and slash flags.
// Depends on fsnp_pkg and fsnp_filter.
`default_nettype none

module fsnp_name_build
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [7:0]                    char_in,
    input  wire logic                          last,
    output logic      [fsnp_pkg::BASE_W-1:0]   base_cur,
    output logic      [fsnp_pkg::EXT_W-1:0]    ext_cur
);

    logic [fsnp_pkg::BASE_W-1:0] base_reg, base_next;
    logic [fsnp_pkg::EXT_W-1:0]  ext_reg, ext_next;
    logic [fsnp_pkg::BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [fsnp_pkg::ECNT_W-1:0] ecnt_reg, ecnt_next;
    logic                        dot_reg, dot_next;
    logic                        slash_reg, slash_next;

    // Values after an optional restart by a pending slash
    logic [fsnp_pkg::BASE_W-1:0] base_s;
    logic [fsnp_pkg::EXT_W-1:0]  ext_s;
    logic [fsnp_pkg::BCNT_W-1:0] bcnt_s;
    logic [fsnp_pkg::ECNT_W-1:0] ecnt_s;
    logic                        dot_s;
    fsnp_pkg::filt_t             filt;

    fsnp_filter u_filter
    (
        .char_in (char_in),
        .result  (filt)
    );

    assign base_cur = base_reg;
    assign ext_cur  = ext_reg;

    always_comb
    begin
        base_s = slash_reg ? fsnp_pkg::BASE_BLANK : base_reg;
        ext_s  = slash_reg ? fsnp_pkg::EXT_BLANK  : ext_reg;
        bcnt_s = slash_reg ? '0 : bcnt_reg;
        ecnt_s = slash_reg ? '0 : ecnt_reg;
        dot_s  = slash_reg ? 1'b0 : dot_reg;
    end

    // Next state for one word
    always_comb
    begin
        base_next  = base_reg;
        ext_next   = ext_reg;
        bcnt_next  = bcnt_reg;
        ecnt_next  = ecnt_reg;
        dot_next   = dot_reg;
        slash_next = slash_reg;
        if (step)
        begin
            if (last)
            begin
                base_next  = fsnp_pkg::BASE_BLANK;
                ext_next   = fsnp_pkg::EXT_BLANK;
                bcnt_next  = '0;
                ecnt_next  = '0;
                dot_next   = 1'b0;
                slash_next = 1'b0;
            end
            else
            begin
                base_next  = base_s;
                ext_next   = ext_s;
                bcnt_next  = bcnt_s;
                ecnt_next  = ecnt_s;
                dot_next   = dot_s;
                slash_next = 1'b0;
                if (char_in == fsnp_pkg::CHAR_SLASH)
                begin
                    slash_next = 1'b1;
                end
                else if (!dot_s && char_in == fsnp_pkg::CHAR_DOT)
                begin
                    dot_next = 1'b1;
                end
                else if (filt.keep)
                begin
                    if (!dot_s)
                    begin
                        if (bcnt_s < fsnp_pkg::BCNT_W'(fsnp_pkg::BASE_LEN))
                        begin
                            // first character goes to the top byte
                            for (int i = 0; i < fsnp_pkg::BASE_LEN; i++)
                            begin
                                if (bcnt_s == fsnp_pkg::BCNT_W'(i))
                                begin
                                    base_next[(fsnp_pkg::BASE_LEN-1-i)*8 +: 8] =
                                        filt.char_out;
                                end
                            end
                            bcnt_next = bcnt_s + 1'b1;
                        end
                    end
                    else if (ecnt_s < fsnp_pkg::ECNT_W'(fsnp_pkg::EXT_LEN))
                    begin
                        for (int i = 0; i < fsnp_pkg::EXT_LEN; i++)
                        begin
                            if (ecnt_s == fsnp_pkg::ECNT_W'(i))
                            begin
                                ext_next[(fsnp_pkg::EXT_LEN-1-i)*8 +: 8] =
                                    filt.char_out;
                            end
                        end
                        ecnt_next = ecnt_s + 1'b1;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= fsnp_pkg::BASE_BLANK;
            ext_reg   <= fsnp_pkg::EXT_BLANK;
            bcnt_reg  <= '0;
            ecnt_reg  <= '0;
            dot_reg   <= 1'b0;
            slash_reg <= 1'b0;
        end
        else
        begin
            base_reg  <= base_next;
            ext_reg   <= ext_next;
            bcnt_reg  <= bcnt_next;
            ecnt_reg  <= ecnt_next;
            dot_reg   <= dot_next;
            slash_reg <= slash_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/fat_short_name_from_path_top.sv =====
// Top level of the FAT 8.3 short name builder: input register, name state,
// result register. Depends on fsnp_pkg and fsnp_name_build.
//
//  channel  | dir | tdata                                   | tlast
//  s_axis   | in  | [7:0] path_byte                         | end_of_path
//  m_axis   | out | [63:0] base_chars, [87:64] ext_chars    | -
//
// Each word is held in the input register; the name state updates
// as it leaves. A terminator loads the result register as it leaves.
// One word per cycle is sustained; s_axis_tready drops only while a
// terminator waits behind a result not yet taken.
// rst_n clears the name to spaces and empties both registers.
`default_nettype none

module fat_short_name_from_path_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] path_byte
    input  wire logic        s_axis_tlast,   // end_of_path
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [87:0] m_axis_tdata    // [63:0] base_chars, [87:64] ext_chars
);

    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   in_char_reg;
    logic                         in_last_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [fsnp_pkg::BASE_W-1:0]  out_base_reg;
    logic [fsnp_pkg::EXT_W-1:0]   out_ext_reg;
    logic [fsnp_pkg::BASE_W-1:0]  base_cur;
    logic [fsnp_pkg::EXT_W-1:0]   ext_cur;
    logic                         advance;
    logic                         emit;

    // Input word moves on unless it is a terminator blocked by a full output not being taken
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign emit    = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    fsnp_name_build u_build
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .char_in  (in_char_reg),
        .last     (in_last_reg),
        .base_cur (base_cur),
        .ext_cur  (ext_cur)
    );

    always_comb
    begin
        in_valid_next  = (s_axis_tvalid && s_axis_tready) || (in_valid_reg && !advance);
        out_valid_next = emit || (out_valid_reg && !m_axis_tready);
    end

    // Handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (emit)
        begin
            out_base_reg <= base_cur;
            out_ext_reg  <= ext_cur;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_ext_reg, out_base_reg};

`ifndef ASSERT_OFF
    // A terminator that leaves the input register always produces a result
    a_emit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("terminator did not produce a result");

    // Backpressure only comes from a terminator waiting on a full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without cause");

    // A result that is not taken and not replaced keeps its value
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending result changed");
`endif

endmodule

`default_nettype wire
